// ===== rtl/core/tod_pkg.sv =====
// ----------------------------------------------------------------------------
// tod_pkg: shared types and constants for the time-of-day clock
// Command codes, time unit lengths, reciprocal constants for the
// seconds/minutes/hours split and the chunk tables for the day reduction.
// ----------------------------------------------------------------------------
package tod_pkg;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  localparam logic [36:0] DAY_US    = 37'd86400000000;
  localparam logic [36:0] HOUR_US   = 37'd3600000000;
  localparam logic [36:0] MINUTE_US = 37'd60000000;
  localparam logic [36:0] SECOND_US = 37'd1000000;

  // The day length is 2^13 times an odd factor, so the low 13 bits of the
  // elapsed time pass through and only the upper part is reduced.
  localparam int          TICK_SHIFT = 13;
  localparam longint      TICK_MOD   = 64'd10546875;

  // Reciprocals: seconds = (micros >> 6) / 15625, hours = (secs >> 4) / 225,
  // whole minutes = (secs >> 2) / 15. All are exact over the ranges used.
  localparam logic [31:0] SEC_RECIP  = 32'd2251799814;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [15:0] MIN_RECIP  = 16'd34953;

  typedef logic [23:0] mod_tbl_t [128];

  // 2^e reduced by the odd factor, by repeated doubling.
  function automatic longint pow2_mod(input int e);
    longint r;
    r = 1;
    for (int i = 0; i < e; i++) begin
      r = r * 2;
      if (r >= TICK_MOD) r = r - TICK_MOD;
    end
    return r;
  endfunction

  // Entry j holds j * w reduced by the odd factor.
  function automatic mod_tbl_t build_tbl(input longint w);
    mod_tbl_t t;
    longint   acc;
    acc = 0;
    for (int j = 0; j < 128; j++) begin
      t[j] = 24'(acc);
      acc  = acc + w;
      if (acc >= TICK_MOD) acc = acc - TICK_MOD;
    end
    return t;
  endfunction

  localparam mod_tbl_t CHUNK_TBL0 = build_tbl(pow2_mod(24));
  localparam mod_tbl_t CHUNK_TBL1 = build_tbl(pow2_mod(31));
  localparam mod_tbl_t CHUNK_TBL2 = build_tbl(pow2_mod(38));
  localparam mod_tbl_t CHUNK_TBL3 = build_tbl(pow2_mod(45));

endpackage

// ===== rtl/core/time_of_day_clock.sv =====
// ----------------------------------------------------------------------------
// time_of_day_clock: microsecond time of day kept from counter snapshots
// Set loads hours, minutes and seconds; advance adds the time elapsed since
// the last set or advance and wraps at one day; every item returns the time.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                              | Direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, in_cmd, in_timestamp,          | in
//          | in_set_hours, in_set_minutes, in_set_seconds       |
//  result  | out_valid, out_stall, out_hours, out_minutes,      | out
//          | out_seconds, out_micros_of_day, out_day_rolled     |
//
//  One item per cycle is sustained while out_stall is low. An accepted item
//  passes through the eight-register pipeline, stage 0 to stage 7, before
//  it is presented on the result ports.
//  Reset (rst_n low, synchronous) clears the clock and the base timestamp.
//  Each stage advances when the stage behind it is empty or moving, so a
//  stall on the result side fills bubbles before it reaches in_stall.
//
module time_of_day_clock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_timestamp,
  input  logic [4:0]  in_set_hours,
  input  logic [5:0]  in_set_minutes,
  input  logic [5:0]  in_set_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [36:0] out_micros_of_day,
  output logic        out_day_rolled
);

  localparam int NSTAGE = 8;

  // Stage valid bits and the per-stage load condition.
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE-1:0] en;

  // Architectural state: time of day and the base counter value.
  logic [36:0] clock_r, clock_nxt;
  logic [63:0] base_r;

  // Stage 0: input register.
  tod_pkg::cmd_t s0_cmd_r;
  logic [63:0]   s0_stamp_r;
  logic [4:0]    s0_hh_r;
  logic [5:0]    s0_mm_r;
  logic [5:0]    s0_ss_r;

  // Stage 1: elapsed time and the raw set value.
  tod_pkg::cmd_t s1_cmd_r;
  logic [63:0]   s1_elapsed_r;
  logic [36:0]   s1_traw_r;

  // Stage 2: chunk sum of the upper elapsed bits, day overflow, set value.
  tod_pkg::cmd_t s2_cmd_r;
  logic [25:0]   s2_sum_r;
  logic [12:0]   s2_low_r;
  logic          s2_big_r;
  logic [36:0]   s2_tset_r;

  // Stage 3: elapsed time reduced to below one day.
  tod_pkg::cmd_t s3_cmd_r;
  logic [36:0]   s3_emod_r;
  logic          s3_big_r;
  logic [36:0]   s3_tset_r;

  // Stage 4: time after the item.
  logic [36:0]   s4_micros_r;
  logic          s4_rolled_r;

  // Stage 5: seconds reciprocal product.
  logic [62:0]   s5_prod_r;
  logic [36:0]   s5_micros_r;
  logic          s5_rolled_r;

  // Stage 6: seconds of day, hours and whole minutes of day.
  logic [16:0]   s6_secs_r;
  logic [4:0]    s6_hours_r;
  logic [10:0]   s6_mtot_r;
  logic [36:0]   s6_micros_r;
  logic          s6_rolled_r;

  // Stage 7: result register.
  logic [4:0]    s7_hours_r;
  logic [5:0]    s7_minutes_r;
  logic [5:0]    s7_seconds_r;
  logic [36:0]   s7_micros_r;
  logic          s7_rolled_r;

  // Combinational values between stages.
  logic [63:0] elapsed_c;
  logic [36:0] traw_c;
  logic [50:0] upper_c;
  logic [25:0] sum_c;
  logic [25:0] rem_c;
  logic [37:0] acc_c;
  logic        rolled_c;
  logic [26:0] hprod_c;
  logic [30:0] mprod_c;
  logic [16:0] secs_c;

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    en[0] = rdy[0] && in_valid;
    for (int k = 1; k < NSTAGE; k++) begin
      en[k] = rdy[k] && vld_r[k-1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTAGE-1];

  // --------------------------------------------------------------------------
  // Datapath.
  // --------------------------------------------------------------------------
  // Stage 0 to 1: elapsed time modulo 2^64 and the weighted set value.
  assign elapsed_c = s0_stamp_r - base_r;
  assign traw_c    = 37'(s0_hh_r) * tod_pkg::HOUR_US
                   + 37'(s0_mm_r) * tod_pkg::MINUTE_US
                   + 37'(s0_ss_r) * tod_pkg::SECOND_US;

  // Stage 1 to 2: the bits above the low 13 are split into a 24-bit part
  // and four chunks of 7, 7, 7 and 6 bits, each weighted through its own table.
  assign upper_c = s1_elapsed_r[63:tod_pkg::TICK_SHIFT];
  assign sum_c   = 26'(upper_c[23:0])
                 + 26'(tod_pkg::CHUNK_TBL0[upper_c[30:24]])
                 + 26'(tod_pkg::CHUNK_TBL1[upper_c[37:31]])
                 + 26'(tod_pkg::CHUNK_TBL2[upper_c[44:38]])
                 + 26'(tod_pkg::CHUNK_TBL3[{1'b0, upper_c[50:45]}]);

  // Stage 2 to 3: the chunk sum stays below six times the odd factor, so
  // the largest multiple not above it is found by parallel compares.
  always_comb begin
    rem_c = s2_sum_r;
    for (int k = 1; k <= 5; k++) begin
      if (s2_sum_r >= 26'(k * tod_pkg::TICK_MOD)) begin
        rem_c = s2_sum_r - 26'(k * tod_pkg::TICK_MOD);
      end
    end
  end

  // Stage 3 to 4: apply the command to the clock.
  always_comb begin
    clock_nxt = clock_r;
    rolled_c  = 1'b0;
    acc_c     = 38'(clock_r) + 38'(s3_emod_r);
    unique case (s3_cmd_r)
      tod_pkg::CMD_SET: begin
        clock_nxt = s3_tset_r;
      end
      tod_pkg::CMD_ADVANCE: begin
        // Elapsed time of a day or more always crosses midnight.
        rolled_c = s3_big_r || (acc_c >= 38'(tod_pkg::DAY_US));
        if (acc_c >= 38'(tod_pkg::DAY_US)) begin
          clock_nxt = 37'(acc_c - 38'(tod_pkg::DAY_US));
        end else begin
          clock_nxt = acc_c[36:0];
        end
      end
      default: begin
        clock_nxt = clock_r;
      end
    endcase
  end

  // Stage 5 to 6: seconds of day, then hours and minutes of day from it.
  assign secs_c  = s5_prod_r[61:45];
  assign hprod_c = 27'(secs_c[16:4]) * 27'(tod_pkg::HOUR_RECIP);
  assign mprod_c = 31'(secs_c[16:2]) * 31'(tod_pkg::MIN_RECIP);

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      clock_r <= '0;
      base_r  <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (en[1] && (s0_cmd_r == tod_pkg::CMD_SET || s0_cmd_r == tod_pkg::CMD_ADVANCE)) begin
        base_r <= s0_stamp_r;
      end
      if (en[4]) begin
        clock_r <= clock_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_cmd_r   <= tod_pkg::cmd_t'(in_cmd);
      s0_stamp_r <= in_timestamp;
      s0_hh_r    <= in_set_hours;
      s0_mm_r    <= in_set_minutes;
      s0_ss_r    <= in_set_seconds;
    end
    if (en[1]) begin
      s1_cmd_r     <= s0_cmd_r;
      s1_elapsed_r <= elapsed_c;
      s1_traw_r    <= traw_c;
    end
    if (en[2]) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_sum_r  <= sum_c;
      s2_low_r  <= s1_elapsed_r[tod_pkg::TICK_SHIFT-1:0];
      s2_big_r  <= (s1_elapsed_r >= 64'(tod_pkg::DAY_US));
      s2_tset_r <= (s1_traw_r >= tod_pkg::DAY_US) ? (s1_traw_r - tod_pkg::DAY_US)
                                                   : s1_traw_r;
    end
    if (en[3]) begin
      s3_cmd_r  <= s2_cmd_r;
      s3_emod_r <= {rem_c[23:0], s2_low_r};
      s3_big_r  <= s2_big_r;
      s3_tset_r <= s2_tset_r;
    end
    if (en[4]) begin
      s4_micros_r <= clock_nxt;
      s4_rolled_r <= rolled_c;
    end
    if (en[5]) begin
      s5_prod_r   <= 63'(s4_micros_r[36:6]) * 63'(tod_pkg::SEC_RECIP);
      s5_micros_r <= s4_micros_r;
      s5_rolled_r <= s4_rolled_r;
    end
    if (en[6]) begin
      s6_secs_r   <= secs_c;
      s6_hours_r  <= hprod_c[25:21];
      s6_mtot_r   <= mprod_c[29:19];
      s6_micros_r <= s5_micros_r;
      s6_rolled_r <= s5_rolled_r;
    end
    if (en[7]) begin
      s7_hours_r   <= s6_hours_r;
      s7_minutes_r <= 6'(s6_mtot_r - 11'(s6_hours_r) * 11'd60);
      s7_seconds_r <= 6'(s6_secs_r - 17'(s6_mtot_r) * 17'd60);
      s7_micros_r  <= s6_micros_r;
      s7_rolled_r  <= s6_rolled_r;
    end
  end

  assign out_hours         = s7_hours_r;
  assign out_minutes       = s7_minutes_r;
  assign out_seconds       = s7_seconds_r;
  assign out_micros_of_day = s7_micros_r;
  assign out_day_rolled    = s7_rolled_r;

`ifndef SYNTHESIS
  // The kept time of day never reaches one day.
  a_clock_below_day: assert property (@(posedge clk) disable iff (!rst_n)
    clock_r < tod_pkg::DAY_US)
    else $error("clock value reached one day");

  // With the result register empty, every stage can load.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  // The split fields stay within their ranges.
  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hours < 5'd24 && out_minutes < 6'd60 && out_seconds < 6'd60))
    else $error("time fields out of range");

  // An accepted item is held in the input register next cycle.
  a_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item lost at the input register");
`endif

endmodule
